FILE: rtl/core/olid_pkg.sv
// Shared types and codes for the ordered list insert/delete unit.
// No dependencies; imported by olid_cell and ordered_list_insert_delete_unit.
package olid_pkg;

	localparam int DATA_W         = 32;
	localparam int POS_W          = 4;
	localparam int COUNT_OUT_W    = 5;
	localparam int CAPACITY_DFLT  = 16;
	// Positions beyond this many cells cannot be addressed by the position field.
	localparam int READ_TAPS      = 1 << POS_W;

	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_APPEND = 2'd1,
		OP_INSERT = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Broadcast command from the top level to every cell of the row.
	typedef struct packed {
		logic              ins;
		logic              del;
		logic [DATA_W-1:0] data;
	} cell_ctl_t;

endpackage

FILE: rtl/core/ordered_list_insert_delete_unit.sv
// Top level of the ordered list insert/delete unit: request decode, fill count,
// read-out mux and the row of olid_cell storage cells. Depends on olid_pkg.
//
// Usage:
// A request beat is offered on operation, position and value with start high;
// it is taken at the rising edge where start is high and busy is low. This
// unit never raises busy, so a new request can be taken in every cycle.
// Each request gives exactly one result beat: status, read_value and
// entry_count are valid in the cycle where done is high, which is the cycle
// right after the request was taken. The receiver cannot stall; a result is
// shown for exactly that one cycle and then replaced.
// Throughput is one request per cycle. That figure is set by the cell row:
// every cell loads from itself, its lower neighbor, its upper neighbor or the
// request value together, so a whole insert or delete shift is done
// in one step, and the fill count is updated in the same edge.
// Reset (arst_n low) clears the fill count and the result strobe at once.
// Entry contents are not cleared; entries at or above the fill count are
// never returned, so no clearing pass is needed and the unit can take a
// request in the first cycle after reset.
// Reads at positions that the list holds return the entry; rejected reads
// and all other requests return zero in read_value.
module ordered_list_insert_delete_unit import olid_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DFLT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              operation,
	input  logic [POS_W-1:0]        position,
	input  logic signed [DATA_W-1:0] value,
	output logic                    done,
	output logic [1:0]              status,
	output logic signed [DATA_W-1:0] read_value,
	output logic [COUNT_OUT_W-1:0]  entry_count
);

	// Fill count holds 0..CAPACITY; comparisons against the position use
	// whichever of the two widths is larger.
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nxt;
	logic              done_q;
	status_t           status_q;
	logic [DATA_W-1:0] read_value_q;
	logic [COUNT_OUT_W-1:0] entry_count_q;

	op_t               op;
	status_t           status_nxt;
	logic [DATA_W-1:0] rd_nxt;
	logic              full;
	logic              empty;
	logic [IDX_W-1:0]  pos_ext;
	logic [IDX_W-1:0]  count_ext;
	logic [IDX_W-1:0]  sel_idx;
	cell_ctl_t         ctl;
	logic              take;

	logic [DATA_W-1:0] cell_q   [CAPACITY];
	logic [DATA_W-1:0] read_tap [READ_TAPS];

	// The row never holds off a request.
	assign busy = 1'b0;
	assign take = start && !busy;

	assign op        = op_t'(operation);
	assign full      = (count_q == CAP_CNT);
	assign empty     = (count_q == '0);
	assign pos_ext   = IDX_W'(position);
	assign count_ext = IDX_W'(count_q);

	// Only the first cells can be addressed by a read; missing taps read zero.
	for (genvar k = 0; k < READ_TAPS; k++) begin : g_tap
		if (k < CAPACITY) begin : g_live
			assign read_tap[k] = cell_q[k];
		end else begin : g_none
			assign read_tap[k] = '0;
		end
	end

	// Request decode. An append is carried out as an insert at the fill
	// count, so the cells see only two kinds of shift.
	always_comb begin
		status_nxt = ST_OK;
		rd_nxt     = '0;
		count_nxt  = count_q;
		sel_idx    = pos_ext;
		ctl.ins    = 1'b0;
		ctl.del    = 1'b0;
		ctl.data   = value;
		unique case (op)
			OP_READ: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else if (pos_ext >= count_ext) begin
					status_nxt = ST_RANGE;
				end else begin
					rd_nxt = read_tap[position];
				end
			end
			OP_APPEND: begin
				sel_idx = count_ext;
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					ctl.ins   = take;
					count_nxt = count_q + 1'b1;
				end
			end
			OP_INSERT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else if (pos_ext > count_ext) begin
					status_nxt = ST_RANGE;
				end else begin
					ctl.ins   = take;
					count_nxt = count_q + 1'b1;
				end
			end
			OP_DELETE: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else if (pos_ext >= count_ext) begin
					status_nxt = ST_RANGE;
				end else begin
					ctl.del   = take;
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
				status_nxt = ST_RANGE;
			end
		endcase
	end

	// The cell row. The bottom cell has no lower neighbor and the top cell
	// keeps its own value when the row closes up on a delete.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_q[i];
		end else begin : g_mid_r
			assign right_d = cell_q[i+1];
		end
		olid_cell #(
			.IDX_W (IDX_W),
			.INDEX (i)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.sel_idx (sel_idx),
			.left_q  (left_d),
			.right_q (right_d),
			.entry_q (cell_q[i])
		);
	end

	// Fill count and result strobe are control state and reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= take;
			if (take) begin
				count_q <= count_nxt;
			end
		end
	end

	// Result payload needs no reset; it is only looked at under done.
	always_ff @(posedge clk) begin
		if (take) begin
			status_q      <= status_nxt;
			read_value_q  <= rd_nxt;
			entry_count_q <= COUNT_OUT_W'(count_nxt);
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign entry_count = entry_count_q;

	// The fill count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("fill count above capacity");

	// Every taken request gives exactly one result in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> done)
		else $error("result missing after request");

	// A rejected request leaves the fill count as it was.
	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		take && (status_nxt != ST_OK) |=> count_q == $past(count_q))
		else $error("rejected request changed fill count");

	// A result after an accepted append or insert reports a grown list.
	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		take && (status_nxt == ST_OK) && (op == OP_APPEND || op == OP_INSERT)
		|=> count_q == $past(count_q) + 1'b1)
		else $error("fill count did not grow");

endmodule

FILE: rtl/core/olid_cell.sv
// One storage cell of the list row: holds one entry and shifts with its neighbors.
// Depends on olid_pkg.
module olid_cell import olid_pkg::*; #(
	parameter int IDX_W = 5,
	parameter int INDEX = 0
) (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [IDX_W-1:0]  sel_idx,
	input  logic [DATA_W-1:0] left_q,
	input  logic [DATA_W-1:0] right_q,
	output logic [DATA_W-1:0] entry_q
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic at_sel;
	logic past_sel;

	assign at_sel   = (MY_IDX == sel_idx);
	assign past_sel = (MY_IDX >= sel_idx);

	// Insert opens a gap at the selected cell; delete closes it from above.
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (at_sel) begin
				entry_q <= ctl.data;
			end else if (past_sel) begin
				entry_q <= left_q;
			end
		end else if (ctl.del) begin
			if (past_sel) begin
				entry_q <= right_q;
			end
		end
	end

endmodule
